// File: rtl/snx_pkg.sv
// Shared constants, tables, types and helpers of the 3D simplex noise unit.
`timescale 1ns / 1ps
package snx_pkg;

   localparam int SNX_FRAC_BITS = 16;
   localparam int SNX_STAGES = 13;
   localparam int SNX_OFS_W = 27;
   localparam int SNX_A_W = 25;
   localparam int SNX_DOT_W = 29;
   localparam int SNX_TERM_W = 54;

   // 0.6 in Q.48 and the per-corner step of 2^24 / 6 (integer part).
   localparam logic signed [53:0] SNX_WEIGHT_06 = 54'sd168884986026394;
   localparam logic [SNX_OFS_W-1:0] SNX_CORNER_STEP = 27'd2796202;
   localparam logic [SNX_OFS_W-1:0] SNX_ONE_Q24 = 27'd16777216;

   typedef struct packed {
      logic x;
      logic y;
      logic z;
   } snx_step_type;

   localparam logic [7:0] SNX_PERM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

   localparam logic signed [1:0] SNX_GRAD [16][3] = '{
      '{ 2'sd1,  2'sd0,  2'sd1}, '{ 2'sd0,  2'sd1,  2'sd1},
      '{-2'sd1,  2'sd0,  2'sd1}, '{ 2'sd0, -2'sd1,  2'sd1},
      '{ 2'sd1,  2'sd0, -2'sd1}, '{ 2'sd0,  2'sd1, -2'sd1},
      '{-2'sd1,  2'sd0, -2'sd1}, '{ 2'sd0, -2'sd1, -2'sd1},
      '{ 2'sd1, -2'sd1,  2'sd0}, '{ 2'sd1,  2'sd1,  2'sd0},
      '{-2'sd1,  2'sd1,  2'sd0}, '{-2'sd1, -2'sd1,  2'sd0},
      '{ 2'sd1,  2'sd0,  2'sd1}, '{-2'sd1,  2'sd0,  2'sd1},
      '{ 2'sd0,  2'sd1, -2'sd1}, '{ 2'sd0, -2'sd1, -2'sd1}
   };

   // Gradient component times offset, with the component limited to -1, 0 or 1.
   function automatic logic signed [SNX_OFS_W-1:0] snx_gmul(
      input logic signed [1:0] g,
      input logic signed [SNX_OFS_W-1:0] o
   );
      logic signed [SNX_OFS_W-1:0] r;
      priority if (g == 2'sd1) begin
         r = o;
      end else if (g == -2'sd1) begin
         r = -o;
      end else begin
         r = '0;
      end
      return r;
   endfunction

endpackage

// File: rtl/snx_if.sv
// Valid/ready channel interfaces for sample points and noise results.
`timescale 1ns / 1ps
interface snx_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic signed [31:0] coord_z;

   modport source (output valid, output coord_x, output coord_y, output coord_z,
                   input ready);
   modport sink (input valid, input coord_x, input coord_y, input coord_z,
                 output ready);
endinterface

interface snx_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink (input valid, input noise_value, output ready);
endinterface

// File: rtl/simplex_noise_3d_unit.sv
// Throughput: one point per cycle; the pipeline advances stage by stage, so bubbles
// close up under an output stall and an item is taken whenever the first stage can move.
// Reset: synchronous, active high; clears every stage valid bit. No memories, no clearing pass.
// Top level of the 3D simplex noise unit.
`timescale 1ns / 1ps
module simplex_noise_3d_unit
   import snx_pkg::*;
#(
   parameter int FRAC_BITS = SNX_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   snx_req_if.sink     req_if,
   snx_rsp_if.source   rsp_if
);

   logic [SNX_STAGES:1] vld_ff, vld_in, adv;
   logic signed [31:0]  coord [3];
   logic [SNX_A_W-1:0]  base_a [3];
   logic [2:0]          base_r [3];
   logic [7:0]          cell_b [3];
   snx_step_type        step1, step2;
   snx_step_type        step_c [4];
   logic signed [SNX_TERM_W-1:0] term [4];
   logic signed [15:0]  res_ff, res_in;

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      adv[SNX_STAGES] = !vld_ff[SNX_STAGES] || rsp_if.ready;
      for (int k = SNX_STAGES - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      for (int k = 1; k <= SNX_STAGES; k++) begin
         if (adv[k]) begin
            vld_in[k] = (k == 1) ? req_if.valid : vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_if.ready = adv[1];
   assign coord[0] = req_if.coord_x;
   assign coord[1] = req_if.coord_y;
   assign coord[2] = req_if.coord_z;

   snx_cell #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cell (
      .clock  (clock),
      .adv    (adv[6:1]),
      .coord  (coord),
      .base_a (base_a),
      .base_r (base_r),
      .cell_b (cell_b),
      .step1  (step1),
      .step2  (step2)
   );

   assign step_c[0] = '0;
   assign step_c[1] = step1;
   assign step_c[2] = step2;
   assign step_c[3] = '1;

   for (genvar c = 0; c < 4; c++) begin : g_corner
      snx_corner u_corner (
         .clock      (clock),
         .adv        (adv[12:7]),
         .corner_idx (2'(c)),
         .base_a     (base_a),
         .base_r     (base_r),
         .cell_b     (cell_b),
         .step       (step_c[c]),
         .term       (term[c])
      );
   end

   // Sum of the four corners, times 32 into Q2.14 with round half up, then saturate.
   always_comb begin
      logic signed [55:0] acc, rnd, sh;
      acc = 56'(term[0]) + 56'(term[1]) + 56'(term[2]) + 56'(term[3]);
      rnd = acc + 56'sd268435456;
      sh = rnd >>> 29;
      priority if (sh > 56'sd32767) begin
         res_in = 16'sh7fff;
      end else if (sh < -56'sd32768) begin
         res_in = -16'sh8000;
      end else begin
         res_in = sh[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[SNX_STAGES]) begin
         res_ff <= res_in;
      end
   end

   assign rsp_if.valid = vld_ff[SNX_STAGES];
   assign rsp_if.noise_value = res_ff;

endmodule

// File: rtl/snx_cell.sv
// Skew, lattice floor, in-cell offsets, corner order and offset division by six.
`timescale 1ns / 1ps
module snx_cell
   import snx_pkg::*;
#(
   parameter int FRAC_BITS = SNX_FRAC_BITS
) (
   input  logic                     clock,
   input  logic [6:1]               adv,
   input  logic signed [31:0]       coord [3],
   output logic [SNX_A_W-1:0]       base_a [3],
   output logic [2:0]               base_r [3],
   output logic [7:0]               cell_b [3],
   output snx_step_type             step1,
   output snx_step_type             step2
);

   localparam int VW = 36 - FRAC_BITS;
   localparam int WW = VW + 1;
   localparam int UW = FRAC_BITS + 4;
   localparam int SH = 24 - FRAC_BITS;
   localparam logic [63:0] M3_FULL = (64'd1 << WW) / 64'd3;
   localparam logic [WW-1:0] M3 = M3_FULL[WW-1:0];
   localparam logic [63:0] OFF_FULL = 64'd3 << (VW - 1);
   localparam logic [WW-1:0] OFF = OFF_FULL[WW-1:0];
   localparam logic [25:0] M6 = 26'd44739242;
   localparam logic [27:0] Q5_BIAS = 28'd100663296;

   logic [WW-1:0]     w1_ff [3], w1_in [3], w2_ff [3];
   logic [UW-1:0]     p1_ff [3], p1_in [3], p2_ff [3], p3_ff [3];
   logic [2*WW-1:0]   m2_ff [3], m2_in [3];
   logic [7:0]        c3_ff [3], c3_in [3];
   logic [UW-1:0]     u4_ff [3], u4_in [3];
   logic [7:0]        b4_ff [3], b5_ff [3], b6_ff [3];
   logic [27:0]       q5_ff [3], q5_in [3];
   logic [53:0]       m5_ff [3], m5_in [3];
   snx_step_type      s1_5_ff, s2_5_ff, s1_5_in, s2_5_in, s1_6_ff, s2_6_ff;
   logic [SNX_A_W-1:0] a6_ff [3], a6_in [3];
   logic [2:0]        r6_ff [3], r6_in [3];

   // Stage 1: integer part of three times the skewed coordinate, biased to stay nonnegative.
   always_comb begin
      logic signed [35:0] e [3];
      logic signed [35:0] sum, lin, sh;
      for (int n = 0; n < 3; n++) begin
         e[n] = 36'(coord[n]);
      end
      sum = e[0] + e[1] + e[2];
      for (int n = 0; n < 3; n++) begin
         lin = sum + (e[n] <<< 1) + e[n];
         sh = lin >>> FRAC_BITS;
         w1_in[n] = sh[WW-1:0] + OFF;
         p1_in[n] = coord[n][UW-1:0];
      end
   end

   // Stage 2: reciprocal multiply for the division by three.
   always_comb begin
      for (int n = 0; n < 3; n++) begin
         m2_in[n] = {{WW{1'b0}}, w1_ff[n]} * {{WW{1'b0}}, M3};
      end
   end

   // Stage 3: the estimate may be one short; a single correction fixes it.
   always_comb begin
      logic [WW-1:0] q0, rem;
      for (int n = 0; n < 3; n++) begin
         q0 = m2_ff[n][2*WW-1:WW];
         rem = w2_ff[n] - ((q0 << 1) + q0);
         c3_in[n] = (rem >= WW'(3)) ? q0[7:0] + 8'd1 : q0[7:0];
      end
   end

   // Stage 4: exact offsets in units of 1/(6 * 2^FRAC_BITS), kept modulo 2^UW.
   always_comb begin
      logic [3:0] csum, k;
      csum = c3_ff[0][3:0] + c3_ff[1][3:0] + c3_ff[2][3:0];
      for (int n = 0; n < 3; n++) begin
         k = csum - ((c3_ff[n][3:0] << 2) + (c3_ff[n][3:0] << 1));
         u4_in[n] = (p3_ff[n] << 2) + (p3_ff[n] << 1) + {k, {FRAC_BITS{1'b0}}};
      end
   end

   // Stage 5: corner order and the reciprocal multiply for the division by six.
   // Offsets can be negative, so they are compared signed, and the dividend is
   // lifted by 2^24 times six, which leaves the quotient 2^24 high.
   always_comb begin
      logic signed [UW-1:0] us [3];
      for (int n = 0; n < 3; n++) begin
         us[n] = $signed(u4_ff[n]);
      end
      s1_5_in = '0;
      s2_5_in = '0;
      if (us[0] >= us[1]) begin
         priority if (us[1] >= us[2]) begin
            s1_5_in.x = 1'b1; s2_5_in.x = 1'b1; s2_5_in.y = 1'b1;
         end else if (us[0] >= us[2]) begin
            s1_5_in.x = 1'b1; s2_5_in.x = 1'b1; s2_5_in.z = 1'b1;
         end else begin
            s1_5_in.z = 1'b1; s2_5_in.x = 1'b1; s2_5_in.z = 1'b1;
         end
      end else begin
         priority if (us[1] < us[2]) begin
            s1_5_in.z = 1'b1; s2_5_in.y = 1'b1; s2_5_in.z = 1'b1;
         end else if (us[0] < us[2]) begin
            s1_5_in.y = 1'b1; s2_5_in.y = 1'b1; s2_5_in.z = 1'b1;
         end else begin
            s1_5_in.y = 1'b1; s2_5_in.x = 1'b1; s2_5_in.y = 1'b1;
         end
      end
      for (int n = 0; n < 3; n++) begin
         q5_in[n] = (28'(us[n]) << SH) + 28'd3 + Q5_BIAS;
         m5_in[n] = {26'd0, q5_in[n]} * {28'd0, M6};
      end
   end

   // Stage 6: quotient and remainder of the rounded Q.24 offset by six.
   always_comb begin
      logic [25:0] a0;
      logic [27:0] rem;
      for (int n = 0; n < 3; n++) begin
         a0 = m5_ff[n][53:28];
         rem = q5_ff[n] - ((28'(a0) << 2) + (28'(a0) << 1));
         if (rem >= 28'd6) begin
            a6_in[n] = SNX_A_W'(a0) + SNX_A_W'(1);
            r6_in[n] = 3'(rem - 28'd6);
         end else begin
            a6_in[n] = SNX_A_W'(a0);
            r6_in[n] = rem[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < 3; n++) begin
         if (adv[1]) begin
            w1_ff[n] <= w1_in[n];
            p1_ff[n] <= p1_in[n];
         end
         if (adv[2]) begin
            m2_ff[n] <= m2_in[n];
            w2_ff[n] <= w1_ff[n];
            p2_ff[n] <= p1_ff[n];
         end
         if (adv[3]) begin
            c3_ff[n] <= c3_in[n];
            p3_ff[n] <= p2_ff[n];
         end
         if (adv[4]) begin
            u4_ff[n] <= u4_in[n];
            b4_ff[n] <= c3_ff[n];
         end
         if (adv[5]) begin
            q5_ff[n] <= q5_in[n];
            m5_ff[n] <= m5_in[n];
            b5_ff[n] <= b4_ff[n];
         end
         if (adv[6]) begin
            a6_ff[n] <= a6_in[n];
            r6_ff[n] <= r6_in[n];
            b6_ff[n] <= b5_ff[n];
         end
      end
      if (adv[5]) begin
         s1_5_ff <= s1_5_in;
         s2_5_ff <= s2_5_in;
      end
      if (adv[6]) begin
         s1_6_ff <= s1_5_ff;
         s2_6_ff <= s2_5_ff;
      end
   end

   assign base_a = a6_ff;
   assign base_r = r6_ff;
   assign cell_b = b6_ff;
   assign step1 = s1_6_ff;
   assign step2 = s2_6_ff;

endmodule

// File: rtl/snx_corner.sv
// One simplex corner: offset, falloff weight, gradient hash and weighted dot product.
`timescale 1ns / 1ps
module snx_corner
   import snx_pkg::*;
(
   input  logic                          clock,
   input  logic [12:7]                   adv,
   input  logic [1:0]                    corner_idx,
   input  logic [SNX_A_W-1:0]            base_a [3],
   input  logic [2:0]                    base_r [3],
   input  logic [7:0]                    cell_b [3],
   input  snx_step_type                  step,
   output logic signed [SNX_TERM_W-1:0]  term
);

   logic signed [SNX_OFS_W-1:0] o7_ff [3], o7_in [3], o8_ff [3];
   logic [7:0]  h3_7_ff, h3_7_in, h2_8_ff, h2_8_in;
   logic [7:0]  bx7_ff, by7_ff, bx8_ff;
   logic        sx7_ff, sy7_ff, sx8_ff;
   logic signed [53:0] sq8_ff [3], sq8_in [3];
   logic        pos9_ff, pos9_in, pos10_ff, pos11_ff;
   logic [23:0] t9_ff, t9_in, t10_ff, t10_in, t11_ff, t11_in;
   logic signed [SNX_DOT_W-1:0] d9_ff, d9_in, d10_ff, d11_ff;
   logic signed [SNX_TERM_W-1:0] term12_ff, term12_in;

   // Stage 7: corner offset in Q.24 rebuilt from the shared division by six.
   // The shared quotient arrives one unit (Q.24) high, which is taken off here.
   always_comb begin
      logic [4:0] frac;
      logic [SNX_OFS_W-1:0] base, adj;
      logic stp [3];
      stp[0] = step.x;
      stp[1] = step.y;
      stp[2] = step.z;
      base = (corner_idx[0] ? SNX_CORNER_STEP : '0)
           + (corner_idx[1] ? (SNX_CORNER_STEP << 1) : '0);
      for (int n = 0; n < 3; n++) begin
         frac = {2'b00, base_r[n]} + {1'b0, corner_idx, 2'b00};
         priority if (frac >= 5'd12) begin
            adj = SNX_OFS_W'(2);
         end else if (frac >= 5'd6) begin
            adj = SNX_OFS_W'(1);
         end else begin
            adj = '0;
         end
         o7_in[n] = $signed(SNX_OFS_W'(base_a[n]) + base + adj - SNX_ONE_Q24
                            - (stp[n] ? SNX_ONE_Q24 : '0));
      end
      h3_7_in = SNX_PERM[cell_b[2] + {7'd0, step.z}];
   end

   // Stage 8: squared distances and the second hash level.
   always_comb begin
      for (int n = 0; n < 3; n++) begin
         sq8_in[n] = 54'(o7_ff[n] * o7_ff[n]);
      end
      h2_8_in = SNX_PERM[by7_ff + {7'd0, sy7_ff} + h3_7_ff];
   end

   // Stage 9: falloff weight, last hash level and gradient dot product.
   always_comb begin
      logic signed [53:0] t;
      logic [7:0] h1;
      logic signed [1:0] g [3];
      t = SNX_WEIGHT_06 - sq8_ff[0] - sq8_ff[1] - sq8_ff[2];
      pos9_in = !t[53] && (t != '0);
      t9_in = t[47:24];
      h1 = SNX_PERM[bx8_ff + {7'd0, sx8_ff} + h2_8_ff];
      g = SNX_GRAD[h1[3:0]];
      d9_in = SNX_DOT_W'(snx_gmul(g[0], o8_ff[0]))
            + SNX_DOT_W'(snx_gmul(g[1], o8_ff[1]))
            + SNX_DOT_W'(snx_gmul(g[2], o8_ff[2]));
   end

   // Stages 10 and 11: the weight raised to the fourth power, truncated to Q.24 each time.
   always_comb begin
      logic [47:0] p10, p11;
      p10 = t9_ff * t9_ff;
      t10_in = p10[47:24];
      p11 = t10_ff * t10_ff;
      t11_in = p11[47:24];
   end

   // Stage 12: weighted contribution in Q.48, zero when the corner is out of reach.
   always_comb begin
      logic signed [24:0] w;
      w = $signed({1'b0, t11_ff});
      term12_in = pos11_ff ? SNX_TERM_W'(w * d11_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         o7_ff <= o7_in;
         h3_7_ff <= h3_7_in;
         bx7_ff <= cell_b[0];
         by7_ff <= cell_b[1];
         sx7_ff <= step.x;
         sy7_ff <= step.y;
      end
      if (adv[8]) begin
         sq8_ff <= sq8_in;
         o8_ff <= o7_ff;
         h2_8_ff <= h2_8_in;
         bx8_ff <= bx7_ff;
         sx8_ff <= sx7_ff;
      end
      if (adv[9]) begin
         pos9_ff <= pos9_in;
         t9_ff <= t9_in;
         d9_ff <= d9_in;
      end
      if (adv[10]) begin
         pos10_ff <= pos9_ff;
         t10_ff <= t10_in;
         d10_ff <= d9_ff;
      end
      if (adv[11]) begin
         pos11_ff <= pos10_ff;
         t11_ff <= t11_in;
         d11_ff <= d10_ff;
      end
      if (adv[12]) begin
         term12_ff <= term12_in;
      end
   end

   assign term = term12_ff;

endmodule

// File: rtl/snx_checker.sv
// Port-level checks of the noise unit's transaction flow, bound to the top level.
`timescale 1ns / 1ps
module snx_checker
   import snx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic signed [15:0] noise_value
);

   logic [4:0] cnt_ff, cnt_in;

   // Transactions taken in and not yet delivered.
   always_comb begin
      cnt_in = cnt_ff + 5'(req_valid && req_ready) - 5'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 5'd0)
      else $error("result shown with no transaction outstanding");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 5'(SNX_STAGES))
      else $error("more transactions in flight than pipeline stages");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output register is empty");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_value))
      else $error("stalled result dropped or changed");

endmodule

bind simplex_noise_3d_unit snx_checker u_snx_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .noise_value (rsp_if.noise_value)
);
